@@ hw/rtl/blinn_phong_shader_defines.svh @@
// Assertion macros for the shading pipeline
`ifndef BLINN_PHONG_SHADER_DEFINES_SVH
`define BLINN_PHONG_SHADER_DEFINES_SVH
`ifndef ASSERT_OFF
`define BPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/bps_pkg.sv @@
// Shared types, constants and helpers of the shading pipeline
package bps_pkg;
	localparam int VW = 34;
	localparam int UW = 32;
	localparam int MW = 30;
	localparam int ULAT = 68;
	localparam int SHININESS_DEF = 20;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [UW-1:0] unit_t;

	typedef enum logic [2:0] {
		REG_TYPE   = 3'd0,
		REG_SURF_R = 3'd1,
		REG_SURF_G = 3'd2,
		REG_SURF_B = 3'd3,
		REG_CAM_X  = 3'd4,
		REG_CAM_Y  = 3'd5,
		REG_CAM_Z  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] light_x;
		logic signed [31:0] light_y;
		logic signed [31:0] light_z;
		logic [15:0] light_r;
		logic [15:0] light_g;
		logic [15:0] light_b;
	} hit_t;

	typedef struct packed {
		logic [15:0] out_r;
		logic [15:0] out_g;
		logic [15:0] out_b;
	} shade_t;

	typedef logic [2:0][16:0] base_t;

	typedef struct packed {
		logic [15:0] dnl;
		logic facing;
		base_t base;
	} side_t;

	typedef struct packed {
		logic [2:0][UW-1:0] n;
		side_t side;
	} htag_t;

	function automatic logic [15:0] dot_q15(input logic signed [63:0] d);
		logic [17:0] v;
		v = d[62:45];
		if (d <= 64'sd0) begin
			return 16'd0;
		end else if (v > 18'(ONE_Q15)) begin
			return ONE_Q15;
		end
		return v[15:0];
	endfunction
endpackage

@@ hw/rtl/bps_unit.sv @@
// Pipelined vector normaliser: magnitude scaling, square root and division lanes
module bps_unit #(
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  bps_pkg::vec_t    vec [3],
	input  logic [TW-1:0]    in_tag,
	output logic             out_vld,
	output bps_pkg::unit_t   unit [3],
	output logic [TW-1:0]    out_tag
);
	import bps_pkg::*;

	localparam int SW  = $clog2(VW);
	localparam int SQW = 2 * MW + 2;
	localparam int LW  = MW + 1;
	localparam int RW  = LW + 2;

	typedef logic [VW-1:0] mag_t;
	typedef struct packed {
		logic [2:0] neg;
		logic zero;
		logic [TW-1:0] tag;
		logic [2:0][MW-1:0] m;
	} ctx_t;

	logic vld_a, vld_b, vld_c, vld_d, vld_e;
	mag_t mag_a [3];
	mag_t mag_b [3];
	logic [2:0] neg_a, neg_b;
	logic [TW-1:0] tag_a, tag_b;
	logic zero_b;
	logic [SW-1:0] msb_b;
	mag_t or_c;
	logic [SW-1:0] msb_c;
	mag_t sh_c [3];
	ctx_t ctx_c, ctx_d, ctx_e;
	logic [2*MW-1:0] sq_d [3];
	logic [SQW-1:0] sum_e;

	logic sq_vld [LW];
	logic [SQW-1:0] sq_x [LW];
	logic [RW-1:0] sq_rem [LW];
	logic [LW-1:0] sq_res [LW];
	ctx_t sq_ctx [LW];

	logic dv_vld [LW];
	logic [LW-1:0] dv_len [LW];
	logic [2:0][LW-1:0] dv_rem [LW];
	logic [2:0][LW-1:0] dv_q [LW];
	ctx_t dv_ctx [LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a <= 1'b0;
			vld_b <= 1'b0;
			vld_c <= 1'b0;
			vld_d <= 1'b0;
			vld_e <= 1'b0;
		end else begin
			vld_a <= in_vld;
			vld_b <= vld_a;
			vld_c <= vld_b;
			vld_d <= vld_c;
			vld_e <= vld_d;
		end
	end

	always_comb begin
		or_c = mag_a[0] | mag_a[1] | mag_a[2];
		msb_c = '0;
		for (int i = 0; i < VW; i++) begin
			if (or_c[i]) begin
				msb_c = SW'(i);
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (msb_b >= SW'(MW)) begin
				sh_c[i] = mag_b[i] >> (msb_b - SW'(MW - 1));
			end else begin
				sh_c[i] = mag_b[i] << (SW'(MW - 1) - msb_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_a[i] <= vec[i][VW-1];
			mag_a[i] <= vec[i][VW-1] ? mag_t'(-vec[i]) : mag_t'(vec[i]);
			mag_b[i] <= mag_a[i];
			ctx_c.m[i] <= sh_c[i][MW-1:0];
			sq_d[i] <= (2*MW)'(ctx_c.m[i]) * (2*MW)'(ctx_c.m[i]);
		end
		tag_a <= in_tag;
		neg_b <= neg_a;
		tag_b <= tag_a;
		zero_b <= (or_c == '0);
		msb_b <= msb_c;
		ctx_c.neg <= neg_b;
		ctx_c.zero <= zero_b;
		ctx_c.tag <= tag_b;
		ctx_d <= ctx_c;
		ctx_e <= ctx_d;
		sum_e <= SQW'(sq_d[0]) + SQW'(sq_d[1]) + SQW'(sq_d[2]);
	end

	for (genvar g = 0; g < LW; g++) begin : g_sqrt
		logic [SQW-1:0] x_in;
		logic [RW-1:0] rem_in;
		logic [LW-1:0] res_in;
		logic v_in;
		ctx_t c_in;
		logic [RW+1:0] r2;
		logic [RW+1:0] trial;
		logic ge;
		if (g == 0) begin : g_first
			assign x_in = sum_e;
			assign rem_in = '0;
			assign res_in = '0;
			assign v_in = vld_e;
			assign c_in = ctx_e;
		end else begin : g_next
			assign x_in = sq_x[g-1];
			assign rem_in = sq_rem[g-1];
			assign res_in = sq_res[g-1];
			assign v_in = sq_vld[g-1];
			assign c_in = sq_ctx[g-1];
		end
		always_comb begin
			r2 = {rem_in, x_in[SQW-1 -: 2]};
			trial = (RW+2)'({res_in, 2'b01});
			ge = (r2 >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[g] <= 1'b0;
			end else begin
				sq_vld[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			sq_x[g] <= x_in << 2;
			sq_rem[g] <= ge ? RW'(r2 - trial) : RW'(r2);
			sq_res[g] <= {res_in[LW-2:0], ge};
			sq_ctx[g] <= c_in;
		end
	end

	for (genvar g = 0; g < LW; g++) begin : g_div
		logic [LW-1:0] len_in;
		logic [2:0][LW-1:0] rem_in;
		logic [2:0][LW-1:0] q_in;
		logic [2:0] b_in;
		logic v_in;
		ctx_t c_in;
		logic [LW:0] r2 [3];
		logic [2:0] ge;
		if (g == 0) begin : g_first
			assign len_in = sq_res[LW-1];
			assign v_in = sq_vld[LW-1];
			assign c_in = sq_ctx[LW-1];
			assign q_in = '0;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = LW'(sq_ctx[LW-1].m[i] >> 1);
				assign b_in[i] = sq_ctx[LW-1].m[i][0];
			end
		end else begin : g_next
			assign len_in = dv_len[g-1];
			assign v_in = dv_vld[g-1];
			assign c_in = dv_ctx[g-1];
			assign q_in = dv_q[g-1];
			assign rem_in = dv_rem[g-1];
			assign b_in = '0;
		end
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {rem_in[i], b_in[i]};
				ge[i] = (r2[i] >= {1'b0, len_in});
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[g] <= 1'b0;
			end else begin
				dv_vld[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[g][i] <= ge[i] ? LW'(r2[i] - {1'b0, len_in}) : LW'(r2[i]);
				dv_q[g][i] <= {q_in[i][LW-2:0], ge[i]};
			end
			dv_len[g] <= len_in;
			dv_ctx[g] <= c_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= dv_vld[LW-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_ctx[LW-1].zero) begin
				unit[i] <= '0;
			end else if (dv_ctx[LW-1].neg[i]) begin
				unit[i] <= -unit_t'({1'b0, dv_q[LW-1][i]});
			end else begin
				unit[i] <= unit_t'({1'b0, dv_q[LW-1][i]});
			end
		end
		out_tag <= dv_ctx[LW-1].tag;
	end
endmodule

@@ hw/rtl/blinn_phong_shader.sv @@
// Blinn-Phong shading pipeline for one point light per hit.
// Throughput: one hit per cycle; busy stays low, done strobes one cycle per result.
// Depth is set by four normalisers of 68 stages each (31 square-root and 31 divide
// steps), two on the path, and one multiply stage per power of the specular term.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`include "blinn_phong_shader_defines.svh"
module blinn_phong_shader #(
	parameter int SHININESS = bps_pkg::SHININESS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bps_pkg::hit_t   item,
	output logic            done,
	output bps_pkg::shade_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_addr,
	input  logic [31:0]     cfg_data
);
	import bps_pkg::*;

	localparam int LAT = 7 + 2 * ULAT + SHININESS;

	logic surface_type_q;
	logic [15:0] surf_q [3];
	logic signed [31:0] cam_q [3];

	logic signed [31:0] hit_c [3];
	logic signed [31:0] nrm_c [3];
	logic signed [31:0] lgt_c [3];
	logic [15:0] lc_c [3];
	logic [31:0] bprod_c [3];

	logic vld_s1;
	vec_t nv_s1 [3];
	vec_t lv_s1 [3];
	vec_t cv_s1 [3];
	base_t base_s1;

	logic n_vld, l_vld, v_vld;
	unit_t n_u [3];
	unit_t l_u [3];
	unit_t c_u [3];
	logic [$bits(base_t)-1:0] n_tag;
	logic l_tag, v_tag;

	logic vld_s2;
	vec_t hs_s2 [3];
	logic signed [63:0] pnl_s2 [3];
	unit_t n_s2 [3];
	base_t base_s2;
	logic signed [63:0] dnl_c;

	logic vld_s3;
	vec_t hs_s3 [3];
	htag_t htag_s3;

	logic h_vld;
	unit_t h_u [3];
	logic [$bits(htag_t)-1:0] h_tag;
	htag_t h_tag_c;

	logic vld_s4;
	logic signed [63:0] pnh_s4 [3];
	side_t side_s4;
	logic signed [63:0] dnh_c;

	logic vld_s5;
	logic [15:0] dnh_s5;
	side_t side_s5;

	logic vld_s6 [SHININESS];
	logic [15:0] pw_s6 [SHININESS];
	logic [15:0] dnh_s6 [SHININESS];
	side_t side_s6 [SHININESS];

	logic vld_s7;
	logic [32:0] dif_s7 [3];
	logic [32:0] spc_s7 [3];
	logic add_s7;

	logic vld_s8;
	shade_t out_s8;
	logic [18:0] sum_c [3];
	logic [15:0] clp_c [3];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_type_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				surf_q[i] <= ONE_Q15;
				cam_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_TYPE: begin
					surface_type_q <= cfg_data[0];
				end
				REG_SURF_R: begin
					surf_q[0] <= cfg_data[15:0];
				end
				REG_SURF_G: begin
					surf_q[1] <= cfg_data[15:0];
				end
				REG_SURF_B: begin
					surf_q[2] <= cfg_data[15:0];
				end
				REG_CAM_X: begin
					cam_q[0] <= signed'(cfg_data);
				end
				REG_CAM_Y: begin
					cam_q[1] <= signed'(cfg_data);
				end
				REG_CAM_Z: begin
					cam_q[2] <= signed'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign hit_c[0] = item.hit_x;
	assign hit_c[1] = item.hit_y;
	assign hit_c[2] = item.hit_z;
	assign nrm_c[0] = item.normal_x;
	assign nrm_c[1] = item.normal_y;
	assign nrm_c[2] = item.normal_z;
	assign lgt_c[0] = item.light_x;
	assign lgt_c[1] = item.light_y;
	assign lgt_c[2] = item.light_z;
	assign lc_c[0] = item.light_r;
	assign lc_c[1] = item.light_g;
	assign lc_c[2] = item.light_b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bprod_c[i] = 32'(surf_q[i]) * 32'(lc_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= n_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= h_vld;
			vld_s5 <= vld_s4;
			vld_s7 <= vld_s6[SHININESS-1];
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nv_s1[i] <= VW'(nrm_c[i]);
			lv_s1[i] <= VW'(lgt_c[i]) - VW'(hit_c[i]);
			cv_s1[i] <= VW'(cam_q[i]) - VW'(hit_c[i]);
			base_s1[i] <= bprod_c[i][31:15];
		end
	end

	bps_unit #(.TW($bits(base_t))) u_norm_n (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .vec(nv_s1), .in_tag(base_s1),
		.out_vld(n_vld), .unit(n_u), .out_tag(n_tag)
	);

	bps_unit #(.TW(1)) u_norm_l (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .vec(lv_s1), .in_tag(1'b0),
		.out_vld(l_vld), .unit(l_u), .out_tag(l_tag)
	);

	bps_unit #(.TW(1)) u_norm_v (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .vec(cv_s1), .in_tag(1'b0),
		.out_vld(v_vld), .unit(c_u), .out_tag(v_tag)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hs_s2[i] <= VW'(l_u[i]) + VW'(c_u[i]);
			pnl_s2[i] <= 64'(n_u[i]) * 64'(l_u[i]);
			n_s2[i] <= n_u[i];
			hs_s3[i] <= hs_s2[i];
			htag_s3.n[i] <= n_s2[i];
		end
		base_s2 <= base_t'(n_tag);
		htag_s3.side.dnl <= dot_q15(dnl_c);
		htag_s3.side.facing <= (dnl_c > 64'sd0);
		htag_s3.side.base <= base_s2;
	end

	assign dnl_c = pnl_s2[0] + pnl_s2[1] + pnl_s2[2];

	bps_unit #(.TW($bits(htag_t))) u_norm_h (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s3), .vec(hs_s3), .in_tag(htag_s3),
		.out_vld(h_vld), .unit(h_u), .out_tag(h_tag)
	);

	assign h_tag_c = htag_t'(h_tag);
	assign dnh_c = pnh_s4[0] + pnh_s4[1] + pnh_s4[2];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pnh_s4[i] <= 64'(signed'(h_tag_c.n[i])) * 64'(h_u[i]);
		end
		side_s4 <= h_tag_c.side;
		dnh_s5 <= dot_q15(dnh_c);
		side_s5 <= side_s4;
	end

	for (genvar g = 0; g < SHININESS; g++) begin : g_pow
		logic [15:0] p_in;
		logic [15:0] d_in;
		logic v_in;
		side_t s_in;
		logic [31:0] prod;
		if (g == 0) begin : g_first
			assign p_in = ONE_Q15;
			assign d_in = dnh_s5;
			assign v_in = vld_s5;
			assign s_in = side_s5;
		end else begin : g_next
			assign p_in = pw_s6[g-1];
			assign d_in = dnh_s6[g-1];
			assign v_in = vld_s6[g-1];
			assign s_in = side_s6[g-1];
		end
		assign prod = 32'(p_in) * 32'(d_in);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[g] <= 1'b0;
			end else begin
				vld_s6[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			pw_s6[g] <= prod[30:15];
			dnh_s6[g] <= d_in;
			side_s6[g] <= s_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dif_s7[i] <= 33'(side_s6[SHININESS-1].base[i]) * 33'(side_s6[SHININESS-1].dnl);
			spc_s7[i] <= 33'(side_s6[SHININESS-1].base[i]) * 33'(pw_s6[SHININESS-1]);
		end
		add_s7 <= surface_type_q && side_s6[SHININESS-1].facing;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = 19'(dif_s7[i][32:15]) + (add_s7 ? 19'(spc_s7[i][32:15]) : 19'd0);
			clp_c[i] = (sum_c[i] > 19'(ONE_Q15)) ? ONE_Q15 : sum_c[i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		out_s8.out_r <= clp_c[0];
		out_s8.out_g <= clp_c[1];
		out_s8.out_b <= clp_c[2];
	end

	assign done = vld_s8;
	assign result = out_s8;

	`BPS_ASSERT_IMP(a_latency, clk, arst_n, 1'b1, done == $past(start && arst_n, LAT))
	`BPS_ASSERT_IMP(a_units_aligned, clk, arst_n, n_vld || l_vld || v_vld, n_vld && l_vld && v_vld && !l_tag && !v_tag)
	`BPS_ASSERT_IMP(a_clamped, clk, arst_n, done, result.out_r <= ONE_Q15 && result.out_g <= ONE_Q15 && result.out_b <= ONE_Q15)
	`BPS_ASSERT_NXT(a_rough_no_spec, clk, arst_n, vld_s6[SHININESS-1] && !surface_type_q, !add_s7)
endmodule
